// File: sv/scwg_pkg.sv
// Shared constants, codes and types of the serpentine coverage waypoint generator.
`timescale 1ns / 1ps

package scwg_pkg;

  // Coordinate width of the signed fixed-point waypoint values.
  localparam int CoordBits  = 32;
  localparam int RadiusBits = CoordBits - 2;
  localparam int StepBits   = CoordBits - 1;
  localparam int CfgIdxBits = 3;
  localparam int DivCntBits = $clog2(CoordBits);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_X_LOW    = 3'd0,
    CFG_X_HIGH   = 3'd1,
    CFG_Y_LOW    = 3'd2,
    CFG_Y_HIGH   = 3'd3,
    CFG_ALTITUDE = 3'd4,
    CFG_RADIUS   = 3'd5,
    CFG_STEP     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_ROW  = 2'd0,
    PH_VERT = 2'd1,
    PH_DONE = 2'd2
  } leg_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_EMIT     = 3'd1,
    ST_PREP     = 3'd2,
    ST_DIV_N    = 3'd3,
    ST_DIV_STEP = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic                 start;
    logic [CoordBits-1:0] dividend;
    logic [CoordBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [CoordBits-1:0] quotient;
    logic [CoordBits-1:0] remainder;
  } div_rsp_t;

endpackage

// File: sv/scwg_div.sv
// Restoring unsigned divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module scwg_div import scwg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [CoordBits-1:0]  rem_q, rem_d;
  logic [CoordBits-1:0]  quo_q, quo_d;
  logic [CoordBits-1:0]  dvs_q, dvs_d;
  logic [CoordBits:0]    trial;
  logic                  fit;

  // The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
  assign trial = {rem_q, quo_q[CoordBits-1]};
  assign fit   = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fit ? CoordBits'(trial - {1'b0, dvs_q}) : trial[CoordBits-1:0];
      quo_d = {quo_q[CoordBits-2:0], fit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntBits'(CoordBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: sv/serpentine_coverage_waypoint_generator_top.sv
// Top level of the serpentine coverage waypoint generator.
//
// Each beat on the input channel (in_valid_i, in_stall_o, restart_i) asks for one
// waypoint; restart_i high starts the path over from its first point. Each request
// gives exactly one beat on the output channel (out_valid_o, out_stall_i): the point,
// a final_point flag on the last point and exhausted_o once the path is used up.
// Seven registers are written on the configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i); cfg_ready_o is always high and writes are expected only
// while the block is idle.
// Inside a leg the offset along the leg is an incremental interpolator (quotient plus
// remainder accumulator); an accepted request is held in the emit state until the output
// register is free, and the next request is taken once the result is loaded.
// Starting a leg runs two divisions (one when the leg has no steps) on the shared
// one-bit-per-cycle divider, during which in_stall_o is high; this happens after a
// restart with y_lo <= y_hi and after the last point of any leg but the final row.
// A new request is taken while a result still waits in the output register; a
// stalled output only holds the next result until the register frees up.
// After reset the path is exhausted until the first restart, and the registers hold
// their reset values (radius 1.0, step 0.5, everything else zero).
`timescale 1ns / 1ps

module serpentine_coverage_waypoint_generator_top import scwg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [CoordBits-1:0]  cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [CoordBits-1:0] point_x_o,
  output logic signed [CoordBits-1:0] point_y_o,
  output logic signed [CoordBits-1:0] point_z_o,
  output logic                  final_point_o,
  output logic                  exhausted_o
);

  // Configuration registers.
  logic signed [CoordBits-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q, alt_q;
  logic [RadiusBits-1:0]       radius_q;
  logic [StepBits-1:0]         step_q;

  // Path state.
  ctrl_state_e                 state_q, state_d;
  leg_phase_e                  phase_q, phase_d;
  logic signed [CoordBits-1:0] row_q, row_d;
  logic                        odd_q, odd_d;
  logic [CoordBits-1:0]        idx_q, idx_d;
  logic [CoordBits-1:0]        total_q, total_d;
  logic signed [CoordBits:0]   quot_q, quot_d;
  logic signed [CoordBits-1:0] hold_x_q, hold_x_d;
  logic signed [CoordBits-1:0] walk_q, walk_d;
  logic [CoordBits-1:0]        mag_q, mag_d;
  logic [CoordBits-1:0]        acc_q, acc_d;
  logic [CoordBits-1:0]        acc_rem_q, acc_rem_d;
  logic [CoordBits-1:0]        inc_q, inc_d;
  logic [CoordBits-1:0]        inc_rem_q, inc_rem_d;
  logic                        pend_q, pend_d;

  // Output register.
  logic                        out_valid_q;
  logic signed [CoordBits-1:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  logic                        ofin_q, oexh_q, ofin_d, oexh_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                        in_acc, out_free, out_load;
  logic                        last, fits, fits0;
  logic [CoordBits+1:0]        coord_sum, next_row;
  logic [CoordBits:0]          leg_end, rem_sum;
  logic                        wrap;
  logic                        new_odd;
  logic signed [CoordBits-1:0] row_s, row_e;
  logic [CoordBits:0]          row_quot, quot_abs;
  logic [CoordBits-1:0]        step_eff;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_lo_q   <= '0;
      x_hi_q   <= '0;
      y_lo_q   <= '0;
      y_hi_q   <= '0;
      alt_q    <= '0;
      radius_q <= RadiusBits'(65536);
      step_q   <= StepBits'(32768);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_X_LOW:    x_lo_q   <= cfg_data_i;
        CFG_X_HIGH:   x_hi_q   <= cfg_data_i;
        CFG_Y_LOW:    y_lo_q   <= cfg_data_i;
        CFG_Y_HIGH:   y_hi_q   <= cfg_data_i;
        CFG_ALTITUDE: alt_q    <= cfg_data_i;
        CFG_RADIUS:   radius_q <= cfg_data_i[RadiusBits-1:0];
        CFG_STEP:     step_q   <= cfg_data_i[StepBits-1:0];
        default: ;
      endcase
    end
  end

  // Current point along the leg and the tests that decide what follows it.
  assign coord_sum = quot_q[CoordBits]
                   ? {{2{walk_q[CoordBits-1]}}, walk_q} - {2'b00, acc_q}
                   : {{2{walk_q[CoordBits-1]}}, walk_q} + {2'b00, acc_q};
  assign leg_end   = {walk_q[CoordBits-1], walk_q} + quot_q;
  assign last      = (idx_q == total_q);
  assign next_row  = {{2{row_q[CoordBits-1]}}, row_q} + {3'b000, radius_q, 1'b0};
  assign fits      = $signed(next_row) <= $signed({{2{y_hi_q[CoordBits-1]}}, y_hi_q});
  assign fits0     = y_lo_q <= y_hi_q;

  // Interpolator step: offset grows by d/n, with the remainder carried against n.
  assign rem_sum   = {1'b0, acc_rem_q} + {1'b0, inc_rem_q};
  assign wrap      = rem_sum >= {1'b0, total_q};

  // Row leg endpoints; odd rows run from the high edge back to the low edge.
  assign new_odd   = (state_q == ST_IDLE) ? 1'b0 : !odd_q;
  assign row_s     = new_odd ? x_hi_q : x_lo_q;
  assign row_e     = new_odd ? x_lo_q : x_hi_q;
  assign row_quot  = {row_e[CoordBits-1], row_e} - {row_s[CoordBits-1], row_s};

  assign quot_abs  = quot_q[CoordBits] ? -quot_q : quot_q;
  assign step_eff  = (step_q == '0) ? CoordBits'(1) : {1'b0, step_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (restart_i && fits0) ? ST_PREP : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (phase_q != PH_DONE && last && (phase_q == PH_VERT || fits)) begin
            state_d = ST_PREP;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PREP: state_d = ST_DIV_N;
      ST_DIV_N: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            state_d = pend_q ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = ST_DIV_STEP;
          end
        end
      end
      ST_DIV_STEP: begin
        if (div_rsp.done) begin
          state_d = pend_q ? ST_EMIT : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates and divider requests.
  always_comb begin
    phase_d   = phase_q;
    row_d     = row_q;
    odd_d     = odd_q;
    idx_d     = idx_q;
    total_d   = total_q;
    quot_d    = quot_q;
    hold_x_d  = hold_x_q;
    walk_d    = walk_q;
    mag_d     = mag_q;
    acc_d     = acc_q;
    acc_rem_d = acc_rem_q;
    inc_d     = inc_q;
    inc_rem_d = inc_rem_q;
    pend_d    = pend_q;
    ox_d      = ox_q;
    oy_d      = oy_q;
    oz_d      = oz_q;
    ofin_d    = ofin_q;
    oexh_d    = oexh_q;
    div_req   = '{start: 1'b0, dividend: mag_q, divisor: step_eff};

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && restart_i) begin
          row_d = y_lo_q;
          odd_d = 1'b0;
          if (fits0) begin
            walk_d  = row_s;
            quot_d  = row_quot;
            phase_d = PH_ROW;
            pend_d  = 1'b1;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (phase_q == PH_DONE) begin
            ox_d   = '0;
            oy_d   = '0;
            oz_d   = '0;
            ofin_d = 1'b0;
            oexh_d = 1'b1;
          end else begin
            ox_d   = (phase_q == PH_ROW) ? coord_sum[CoordBits-1:0] : hold_x_q;
            oy_d   = (phase_q == PH_ROW) ? row_q : coord_sum[CoordBits-1:0];
            oz_d   = alt_q;
            ofin_d = last && (phase_q == PH_ROW) && !fits;
            oexh_d = 1'b0;
            if (!last) begin
              idx_d     = idx_q + 1'b1;
              acc_d     = acc_q + inc_q + CoordBits'(wrap);
              acc_rem_d = wrap ? CoordBits'(rem_sum - {1'b0, total_q})
                               : rem_sum[CoordBits-1:0];
            end else if (phase_q == PH_ROW) begin
              if (fits) begin
                hold_x_d = leg_end[CoordBits-1:0];
                walk_d   = row_q;
                quot_d   = {2'b00, radius_q, 1'b0};
                phase_d  = PH_VERT;
                pend_d   = 1'b0;
              end else begin
                phase_d = PH_DONE;
              end
            end else begin
              row_d   = leg_end[CoordBits-1:0];
              odd_d   = new_odd;
              walk_d  = row_s;
              quot_d  = row_quot;
              phase_d = PH_ROW;
              pend_d  = 1'b0;
            end
          end
        end
      end
      ST_PREP: begin
        mag_d   = quot_abs[CoordBits-1:0];
        div_req = '{start: 1'b1, dividend: quot_abs[CoordBits-1:0], divisor: step_eff};
      end
      ST_DIV_N: begin
        if (div_rsp.done) begin
          total_d   = div_rsp.quotient;
          idx_d     = '0;
          acc_d     = '0;
          acc_rem_d = '0;
          // The increment d/n is only needed when the leg has steps.
          if (div_rsp.quotient != '0) begin
            div_req = '{start: 1'b1, dividend: mag_q, divisor: div_rsp.quotient};
          end
        end
      end
      ST_DIV_STEP: begin
        if (div_rsp.done) begin
          inc_d     = div_rsp.quotient;
          inc_rem_d = div_rsp.remainder;
        end
      end
      default: ;
    endcase
  end

  scwg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_DONE;
      row_q       <= '0;
      odd_q       <= 1'b0;
      idx_q       <= '0;
      total_q     <= '0;
      quot_q      <= '0;
      hold_x_q    <= '0;
      walk_q      <= '0;
      acc_q       <= '0;
      acc_rem_q   <= '0;
      inc_q       <= '0;
      inc_rem_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      row_q       <= row_d;
      odd_q       <= odd_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      quot_q      <= quot_d;
      hold_x_q    <= hold_x_d;
      walk_q      <= walk_d;
      acc_q       <= acc_d;
      acc_rem_q   <= acc_rem_d;
      inc_q       <= inc_d;
      inc_rem_q   <= inc_rem_d;
      pend_q      <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    ox_q   <= ox_d;
    oy_q   <= oy_d;
    oz_q   <= oz_d;
    ofin_q <= ofin_d;
    oexh_q <= oexh_d;
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = ox_q;
  assign point_y_o     = oy_q;
  assign point_z_o     = oz_q;
  assign final_point_o = ofin_q;
  assign exhausted_o   = oexh_q;

  // An exhausted beat carries a zero point and is never the final point.
  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |->
      point_x_o == '0 && point_y_o == '0 && point_z_o == '0 && !final_point_o)
    else $error("exhausted beat with nonzero payload");

  // Between requests the step index never runs past the leg's step count.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && phase_q != PH_DONE |-> idx_q <= total_q)
    else $error("leg index beyond step count");

  // The interpolator remainder stays below the step count.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && total_q != '0 |-> acc_rem_q < total_q && inc_rem_q < total_q)
    else $error("interpolator remainder out of range");

  // The divider only finishes while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV_N || state_q == ST_DIV_STEP)
    else $error("divider result with no one waiting");

  // A result is loaded only into a free output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("output load lost");

endmodule
